/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the temperature regulator scan unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked property, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/tempreg_pkg.sv */
// ----------------------------------------------------------------------------
// Temperature regulator package
// Word types, register indexes, reset values and lookup tables.
// ----------------------------------------------------------------------------
package tempreg_pkg;

  localparam int WINDOW_LEN_DEF = 20;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef enum logic [2:0] {
    CFG_ADJUST_INTERVAL = 3'd0,
    CFG_DUTY_LIMIT      = 3'd1,
    CFG_SETPOINT_LOW    = 3'd2,
    CFG_SETPOINT_HIGH   = 3'd3,
    CFG_PRESS_REPEAT    = 3'd4,
    CFG_FAN_MARGIN      = 3'd5
  } cfg_index_t;

  localparam logic [15:0] ADJUST_INTERVAL_RST = 16'd65000;
  localparam logic [9:0]  DUTY_LIMIT_RST      = 10'd800;
  localparam logic [6:0]  SETPOINT_LOW_RST    = 7'd30;
  localparam logic [6:0]  SETPOINT_HIGH_RST   = 7'd80;
  localparam logic [7:0]  PRESS_REPEAT_RST    = 8'd30;
  localparam logic [3:0]  FAN_MARGIN_RST      = 4'd2;
  localparam logic [6:0]  TARGET_RST          = 7'd40;
  localparam logic [15:0] COUNTDOWN_RST       = 16'd10;

  localparam logic [7:0] GLYPH_CELSIUS = 8'b0011_1001;
  localparam logic [7:0] PHASE_FIRST   = 8'b1000_0000;

  typedef struct packed {
    logic       req_type;
    logic [7:0] adc_sample;
    logic       down_button_n;
    logic       up_button_n;
  } tempreg_in_t;

  typedef struct packed {
    logic [7:0] segment_pattern;
    logic [7:0] digit_enable;
    logic [9:0] pwm_duty;
    logic       fan_on;
    logic [6:0] temperature_deg;
    logic [6:0] setpoint_deg;
  } tempreg_out_t;

  typedef struct packed {
    logic [15:0] adjust_interval;
    logic [9:0]  duty_limit;
    logic [6:0]  setpoint_low;
    logic [6:0]  setpoint_high;
    logic [7:0]  press_repeat;
    logic [3:0]  fan_margin;
  } tempreg_cfg_t;

  // Display and drive values handed from the scan unit to the result register.
  typedef struct packed {
    logic [7:0] segment_pattern;
    logic [7:0] digit_enable;
    logic [9:0] pwm_duty;
    logic       fan_on;
    logic [6:0] temperature_deg;
  } tempreg_disp_t;

  localparam logic [7:0] SEG_ROM [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // Filtered converter level to degrees Celsius.
  localparam logic [6:0] TEMP_ROM [256] = '{
    7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,
    7'd2,   7'd2,   7'd3,   7'd3,   7'd4,   7'd4,   7'd5,   7'd5,
    7'd6,   7'd6,   7'd7,   7'd7,   7'd8,   7'd8,   7'd9,   7'd9,
    7'd10,  7'd10,  7'd11,  7'd11,  7'd12,  7'd12,  7'd13,  7'd13,
    7'd14,  7'd14,  7'd15,  7'd15,  7'd16,  7'd16,  7'd17,  7'd17,
    7'd18,  7'd18,  7'd19,  7'd19,  7'd20,  7'd20,  7'd21,  7'd21,
    7'd22,  7'd22,  7'd23,  7'd23,  7'd23,  7'd24,  7'd24,  7'd25,
    7'd25,  7'd26,  7'd26,  7'd27,  7'd27,  7'd28,  7'd28,  7'd29,
    7'd29,  7'd30,  7'd30,  7'd31,  7'd31,  7'd32,  7'd32,  7'd33,
    7'd33,  7'd34,  7'd34,  7'd35,  7'd35,  7'd36,  7'd36,  7'd37,
    7'd37,  7'd38,  7'd38,  7'd39,  7'd39,  7'd40,  7'd40,  7'd41,
    7'd41,  7'd42,  7'd42,  7'd43,  7'd43,  7'd44,  7'd44,  7'd45,
    7'd45,  7'd46,  7'd46,  7'd47,  7'd47,  7'd48,  7'd48,  7'd49,
    7'd49,  7'd50,  7'd50,  7'd51,  7'd51,  7'd52,  7'd52,  7'd53,
    7'd53,  7'd54,  7'd54,  7'd55,  7'd55,  7'd56,  7'd56,  7'd57,
    7'd57,  7'd58,  7'd58,  7'd59,  7'd59,  7'd60,  7'd60,  7'd61,
    7'd61,  7'd62,  7'd62,  7'd63,  7'd63,  7'd64,  7'd64,  7'd65,
    7'd65,  7'd66,  7'd66,  7'd67,  7'd67,  7'd68,  7'd68,  7'd69,
    7'd69,  7'd70,  7'd70,  7'd71,  7'd71,  7'd72,  7'd72,  7'd73,
    7'd73,  7'd74,  7'd74,  7'd75,  7'd75,  7'd76,  7'd76,  7'd77,
    7'd77,  7'd78,  7'd78,  7'd79,  7'd79,  7'd80,  7'd80,  7'd81,
    7'd81,  7'd82,  7'd82,  7'd83,  7'd83,  7'd84,  7'd84,  7'd85,
    7'd85,  7'd86,  7'd86,  7'd87,  7'd87,  7'd88,  7'd88,  7'd89,
    7'd89,  7'd90,  7'd90,  7'd91,  7'd91,  7'd92,  7'd92,  7'd93,
    7'd93,  7'd94,  7'd94,  7'd95,  7'd95,  7'd96,  7'd96,  7'd97,
    7'd97,  7'd98,  7'd98,  7'd99,  7'd99,  7'd100, 7'd100, 7'd101,
    7'd101, 7'd102, 7'd102, 7'd103, 7'd103, 7'd104, 7'd104, 7'd104,
    7'd105, 7'd105, 7'd106, 7'd106, 7'd107, 7'd107, 7'd108, 7'd108,
    7'd109, 7'd109, 7'd110, 7'd110, 7'd111, 7'd111, 7'd112, 7'd112
  };

  // Segment pattern of a decimal digit; codes above nine show nothing.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    seg_of = (digit < 4'd10) ? SEG_ROM[digit] : 8'h00;
  endfunction

endpackage

/* rtl/temperature_regulator_with_display_top.sv */
// ----------------------------------------------------------------------------
// Temperature regulator with display
// Filters converter samples, handles setpoint buttons and scans a four-digit
// seven-segment display; sets the fan each scan wrap, PWM duty each adjust interval.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                Word
//   in       input      in_valid / in_stall      tempreg_in_t
//   out      output     out_valid / out_stall    tempreg_out_t
//   cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One word per clock is taken while the output is not stalled: a word sits in
// the input register, where the state update (window mean multiply, scan and
// control) is combinational; its result is loaded into the output register.
// Reset is synchronous and leaves every state and control register at its
// starting value at once; the word registers are qualified by the valid flags.
// A stalled output word is held; the input register still fills behind it,
// after which in_stall follows out_stall. cfg_ready is always high.
// ----------------------------------------------------------------------------
module temperature_regulator_with_display_top import tempreg_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  tempreg_in_t  in_word,
  output logic         out_valid,
  input  logic         out_stall,
  output tempreg_out_t out_word,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  tempreg_cfg_t  cfg_regs;
  logic          s1_valid;
  tempreg_in_t   s1_word;
  logic          advance;
  logic          take;
  logic          sample_en;
  logic          tick_en;
  logic [7:0]    level;
  logic [6:0]    target;
  logic [6:0]    target_next;
  tempreg_disp_t disp_next;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign take      = s1_valid && advance;
  assign sample_en = take && (s1_word.req_type == REQ_SAMPLE);
  assign tick_en   = take && (s1_word.req_type == REQ_TICK);
  assign cfg_ready = 1'b1;

  tempreg_filter #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .sample_en  (sample_en),
    .adc_sample (s1_word.adc_sample),
    .level      (level)
  );

  tempreg_setpoint u_setpoint (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_regs),
    .sample_en     (sample_en),
    .down_button_n (s1_word.down_button_n),
    .up_button_n   (s1_word.up_button_n),
    .target        (target),
    .target_next   (target_next)
  );

  tempreg_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .tick_en   (tick_en),
    .level     (level),
    .target    (target),
    .disp_next (disp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid                 <= 1'b0;
      out_valid                <= 1'b0;
      cfg_regs.adjust_interval <= ADJUST_INTERVAL_RST;
      cfg_regs.duty_limit      <= DUTY_LIMIT_RST;
      cfg_regs.setpoint_low    <= SETPOINT_LOW_RST;
      cfg_regs.setpoint_high   <= SETPOINT_HIGH_RST;
      cfg_regs.press_repeat    <= PRESS_REPEAT_RST;
      cfg_regs.fan_margin      <= FAN_MARGIN_RST;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ADJUST_INTERVAL: cfg_regs.adjust_interval <= cfg_data;
          CFG_DUTY_LIMIT:      cfg_regs.duty_limit      <= cfg_data[9:0];
          CFG_SETPOINT_LOW:    cfg_regs.setpoint_low    <= cfg_data[6:0];
          CFG_SETPOINT_HIGH:   cfg_regs.setpoint_high   <= cfg_data[6:0];
          CFG_PRESS_REPEAT:    cfg_regs.press_repeat    <= cfg_data[7:0];
          CFG_FAN_MARGIN:      cfg_regs.fan_margin      <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Word registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word <= in_word;
    end
    if (take) begin
      out_word.segment_pattern <= disp_next.segment_pattern;
      out_word.digit_enable    <= disp_next.digit_enable;
      out_word.pwm_duty        <= disp_next.pwm_duty;
      out_word.fan_on          <= disp_next.fan_on;
      out_word.temperature_deg <= disp_next.temperature_deg;
      out_word.setpoint_deg    <= target_next;
    end
  end

endmodule

/* rtl/tempreg_filter.sv */
// ----------------------------------------------------------------------------
// Moving average filter
// Sliding window of converter bytes with a running total; the rounded mean
// (ties down) is formed by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module tempreg_filter import tempreg_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_en,
  input  logic [7:0] adc_sample,
  output logic [7:0] level
);

  localparam int TOTAL_W    = $clog2(255 * WINDOW_LEN + 1);
  // Adding this bias before the floor division rounds up only when twice the
  // remainder exceeds the window length.
  localparam int ROUND_BIAS = WINDOW_LEN - 1 - WINDOW_LEN / 2;
  localparam int NUM_W      = $clog2(255 * WINDOW_LEN + ROUND_BIAS + 1);
  localparam int SHIFT      = NUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP      = ((1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int PROD_W     = SHIFT + 8;

  logic [7:0]         window [WINDOW_LEN];
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [NUM_W-1:0]   numer;
  logic [PROD_W-1:0]  prod;
  logic [7:0]         level_next;

  assign total_next = total - TOTAL_W'(window[0]) + TOTAL_W'(adc_sample);
  assign numer      = NUM_W'(total_next) + NUM_W'(ROUND_BIAS);
  assign prod       = PROD_W'(numer) * PROD_W'(RECIP);
  assign level_next = prod[SHIFT +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= 8'h00;
      end
      total <= '0;
      level <= 8'h00;
    end else if (sample_en) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[WINDOW_LEN-1] <= adc_sample;
      total                <= total_next;
      level                <= level_next;
    end
  end

endmodule

/* rtl/tempreg_setpoint.sv */
// ----------------------------------------------------------------------------
// Setpoint buttons
// Hold counters for the down and up buttons and the target temperature.
// ----------------------------------------------------------------------------
module tempreg_setpoint import tempreg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tempreg_cfg_t cfg,
  input  logic         sample_en,
  input  logic         down_button_n,
  input  logic         up_button_n,
  output logic [6:0]   target,
  output logic [6:0]   target_next
);

  logic [7:0] down_cnt;
  logic [7:0] up_cnt;
  logic [7:0] down_dec;
  logic [7:0] up_dec;
  logic       down_step;
  logic       up_step;
  logic [7:0] down_cnt_next;
  logic [7:0] up_cnt_next;
  logic [6:0] after_down;
  logic [6:0] after_up;

  assign down_dec  = down_cnt - 8'd1;
  assign up_dec    = up_cnt - 8'd1;
  assign down_step = !down_button_n && (down_dec == 8'd0);
  assign up_step   = !up_button_n && (up_dec == 8'd0);

  // A released button or a completed step reloads the counter.
  assign down_cnt_next = (down_button_n || down_step) ? cfg.press_repeat : down_dec;
  assign up_cnt_next   = (up_button_n || up_step) ? cfg.press_repeat : up_dec;

  // The down button is served first; the up button sees its result.
  assign after_down = (down_step && (target > cfg.setpoint_low)) ? target - 7'd1 : target;
  assign after_up   = (up_step && (after_down < cfg.setpoint_high)) ?
                      after_down + 7'd1 : after_down;

  assign target_next = sample_en ? after_up : target;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_cnt <= PRESS_REPEAT_RST;
      up_cnt   <= PRESS_REPEAT_RST;
      target   <= TARGET_RST;
    end else if (sample_en) begin
      down_cnt <= down_cnt_next;
      up_cnt   <= up_cnt_next;
      target   <= after_up;
    end
  end

endmodule

/* rtl/tempreg_scan.sv */
// ----------------------------------------------------------------------------
// Display scan and control
// Four-place digit scan; on every wrap the temperature is looked up and the fan
// is updated; once the adjust countdown runs out, the PWM duty is nudged towards the setpoint.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tempreg_scan import tempreg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  tempreg_cfg_t  cfg,
  input  logic          tick_en,
  input  logic [7:0]    level,
  input  logic [6:0]    target,
  output tempreg_disp_t disp_next
);

  typedef enum logic [1:0] {
    PH_HUND,
    PH_TENS,
    PH_UNITS,
    PH_GLYPH
  } phase_t;

  phase_t      phase;
  logic [15:0] countdown;
  logic [9:0]  duty_pending;
  logic [9:0]  duty_applied;
  logic [6:0]  mapped;
  logic        hundreds;
  logic [3:0]  tens;
  logic        fan;

  phase_t      phase_next;
  logic [15:0] countdown_next;
  logic [9:0]  duty_pending_next;
  logic [9:0]  duty_applied_next;
  logic [6:0]  mapped_next;
  logic        hundreds_next;
  logic [3:0]  tens_next;
  logic        fan_next;

  logic [6:0]  mapped_new;
  logic [15:0] count_dec;
  logic [6:0]  below_hund;
  logic [14:0] tens_prod;
  logic [3:0]  tens_calc;
  logic [8:0]  units_diff;
  logic [3:0]  units_digit;
  logic [7:0]  pattern_next;

  logic        wrap_tick;
  logic [17:0] ctrl_state;

  assign mapped_new = TEMP_ROM[level];
  assign count_dec  = countdown - 16'd1;

  // Tens digit: multiply by 205 and drop 11 bits, exact below 1029.
  assign below_hund = mapped - (hundreds ? 7'd100 : 7'd0);
  assign tens_prod  = 15'(below_hund) * 15'd205;
  assign tens_calc  = tens_prod[14:11];

  assign units_diff  = 9'(mapped) - (hundreds ? 9'd100 : 9'd0) - 9'(tens) * 9'd10;
  assign units_digit = (!units_diff[8] && (units_diff <= 9'd9)) ? units_diff[3:0] : 4'd10;

  always_comb begin
    phase_next        = phase;
    countdown_next    = countdown;
    duty_pending_next = duty_pending;
    duty_applied_next = duty_applied;
    mapped_next       = mapped;
    hundreds_next     = hundreds;
    tens_next         = tens;
    fan_next          = fan;
    if (tick_en) begin
      unique case (phase)
        PH_HUND: begin
          phase_next = PH_TENS;
          tens_next  = tens_calc;
        end
        PH_TENS:  phase_next = PH_UNITS;
        PH_UNITS: phase_next = PH_GLYPH;
        PH_GLYPH: begin
          phase_next    = PH_HUND;
          mapped_next   = mapped_new;
          hundreds_next = (mapped_new >= 7'd100);
          fan_next      = ({1'b0, mapped_new} >= ({1'b0, target} + 8'(cfg.fan_margin)));
          if (count_dec == 16'd0) begin
            countdown_next = cfg.adjust_interval;
            // The applied duty lags the pending one by a single step.
            if ((mapped_new < target) && (duty_pending < cfg.duty_limit)) begin
              duty_applied_next = duty_pending;
              duty_pending_next = duty_pending + 10'd1;
            end else if ((mapped_new > target) && (duty_pending != 10'd0)) begin
              duty_applied_next = duty_pending;
              duty_pending_next = duty_pending - 10'd1;
            end
          end else begin
            countdown_next = count_dec;
          end
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_next)
      PH_HUND:  pattern_next = hundreds_next ? seg_of(4'd1) : 8'h00;
      PH_TENS:  pattern_next = seg_of(tens_next);
      PH_UNITS: pattern_next = seg_of(units_digit);
      PH_GLYPH: pattern_next = GLYPH_CELSIUS;
    endcase
  end

  assign disp_next.segment_pattern = pattern_next;
  assign disp_next.digit_enable    = PHASE_FIRST >> phase_next;
  assign disp_next.pwm_duty        = duty_applied_next;
  assign disp_next.fan_on          = fan_next;
  assign disp_next.temperature_deg = mapped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUND;
      countdown    <= COUNTDOWN_RST;
      duty_pending <= 10'd0;
      duty_applied <= 10'd0;
      mapped       <= 7'd0;
      hundreds     <= 1'b0;
      tens         <= 4'd0;
      fan          <= 1'b0;
    end else begin
      phase        <= phase_next;
      countdown    <= countdown_next;
      duty_pending <= duty_pending_next;
      duty_applied <= duty_applied_next;
      mapped       <= mapped_next;
      hundreds     <= hundreds_next;
      tens         <= tens_next;
      fan          <= fan_next;
    end
  end

  assign wrap_tick  = tick_en && (phase == PH_GLYPH);
  assign ctrl_state = {fan, mapped, duty_applied};

  `ASSERT_CLK(a_tens_digit, clk, rst, tens <= 4'd9, "tens digit above nine")
  `ASSERT_CLK(a_hund_match, clk, rst, hundreds == (mapped >= 7'd100), "hundreds flag out of step")
  `ASSERT_CLK(a_wrap_only, clk, rst, !wrap_tick |=> $stable(ctrl_state), "control moved off a wrap")

endmodule
